// ===== design/bsm_pkg.sv =====
// Shared types and constants for the bank switch mapper.
// Used by bsm_regs, bsm_xlate and the top level; depends on nothing.
package bsm_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned MapW    = 19;
  localparam int unsigned RamBytes = 8192;
  localparam int unsigned RamAw   = $clog2(RamBytes);

  typedef enum logic [1:0] {
    KindCpuRead  = 2'd0,
    KindCpuWrite = 2'd1,
    KindPpuFetch = 2'd2,
    KindUnused   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TgtNone = 2'd0,
    TgtPrg  = 2'd1,
    TgtRam  = 2'd2,
    TgtChr  = 2'd3
  } target_e;

  // configuration register indexes
  localparam logic [1:0] CfgBankOrder = 2'd0;
  localparam logic [1:0] CfgPrgMask   = 2'd1;
  localparam logic [1:0] CfgChrMask   = 2'd2;

  // register window on the CPU bus, offsets from RegBase
  localparam logic [15:0] RegBase    = 16'h7EF0;
  localparam logic [15:0] RegLast    = 16'h7EFC;
  localparam logic [3:0]  RegChr0    = 4'd0;
  localparam logic [3:0]  RegChr5    = 4'd5;
  localparam logic [3:0]  RegCtrl    = 4'd6;
  localparam logic [3:0]  RegUnlock0 = 4'd7;
  localparam logic [3:0]  RegUnlock2 = 4'd9;
  localparam logic [3:0]  RegPrg0    = 4'd10;
  localparam logic [3:0]  RegPrg2    = 4'd12;

  // work RAM regions and their keys
  localparam logic [15:0] RamBase  = 16'h6000;
  localparam logic [15:0] RamEnd0  = 16'h67FF;
  localparam logic [15:0] RamEnd1  = 16'h6FFF;
  localparam logic [15:0] RamEnd2  = 16'h73FF;
  localparam logic [7:0]  Key0     = 8'hCA;
  localparam logic [7:0]  Key1     = 8'h69;
  localparam logic [7:0]  Key2     = 8'h84;
  localparam logic [15:0] PrgBase  = 16'h8000;

  localparam logic [7:0]  PrgBank2Rst = 8'hFE;
  localparam logic [7:0]  ChrEvenMask = 8'hFE;

  typedef struct packed {
    logic [5:0][7:0] chr_bank;
    logic [2:0][7:0] prg_bank;
    logic [2:0][7:0] unlock;
    logic [7:0]      ctrl;
    logic            bank_order;
    logic [5:0]      prg_mask;
    logic [7:0]      chr_mask;
  } bsm_state_t;

  typedef struct packed {
    logic       en;
    logic [3:0] sel;
    logic [7:0] data;
  } bsm_wr_t;

endpackage

// ===== design/bsm_regs.sv =====
// Mapper state: bank, control and unlock registers plus configuration.
// Depends on bsm_pkg; written by bus writes from bsm_xlate and the cfg port.
module bsm_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  bsm_pkg::bsm_wr_t    wr_i,
  output bsm_pkg::bsm_state_t state_o
);
  import bsm_pkg::*;

  bsm_state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBankOrder: state_d.bank_order = cfg_data_i[0];
        CfgPrgMask:   state_d.prg_mask   = cfg_data_i[5:0];
        CfgChrMask:   state_d.chr_mask   = cfg_data_i;
        default: ;
      endcase
    end
    if (wr_i.en) begin
      if (wr_i.sel <= RegChr5) begin
        state_d.chr_bank[3'(wr_i.sel - RegChr0)] = wr_i.data;
      end else if (wr_i.sel == RegCtrl) begin
        state_d.ctrl = wr_i.data;
      end else if (wr_i.sel <= RegUnlock2) begin
        state_d.unlock[2'(wr_i.sel - RegUnlock0)] = wr_i.data;
      end else if (wr_i.sel <= RegPrg2) begin
        state_d.prg_bank[2'(wr_i.sel - RegPrg0)] = wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.chr_bank   <= '0;
      state_q.prg_bank   <= {PrgBank2Rst, 8'd1, 8'd0};
      state_q.unlock     <= '0;
      state_q.ctrl       <= '0;
      state_q.bank_order <= 1'b0;
      state_q.prg_mask   <= '1;
      state_q.chr_mask   <= '1;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ===== design/bsm_xlate.sv =====
// Address translation for one bus access: target, mapped address, RAM write.
// Depends on bsm_pkg; reads the state from bsm_regs and returns its write.
module bsm_xlate (
  input  logic                    vld_i,
  input  logic [1:0]              kind_i,
  input  logic [15:0]             addr_i,
  input  logic [7:0]              data_i,
  input  bsm_pkg::bsm_state_t     state_i,
  output bsm_pkg::bsm_wr_t        wr_o,
  output bsm_pkg::target_e        target_o,
  output logic [bsm_pkg::MapW-1:0] mapped_o,
  output logic                    ram_write_o,
  output logic                    mirror_o
);
  import bsm_pkg::*;

  logic        is_cpu, in_ram, ram_ok, is_prg;
  logic [1:0]  win;
  logic [7:0]  prg_raw;
  logic [5:0]  prg_dec, prg_bank;
  logic [12:0] ppu_a;
  logic [7:0]  chr_bank;
  logic [15:0] ram_off;
  logic        ctrl_wr;

  always_comb begin
    is_cpu = (kind_i == KindCpuRead) || (kind_i == KindCpuWrite);
    in_ram = (addr_i >= RamBase) && (addr_i <= RamEnd2);
    if (addr_i <= RamEnd0)      ram_ok = (state_i.unlock[0] == Key0);
    else if (addr_i <= RamEnd1) ram_ok = (state_i.unlock[1] == Key1);
    else                        ram_ok = (state_i.unlock[2] == Key2);
    ram_off = addr_i - RamBase;

    // program window decode
    win     = addr_i[14:13];
    prg_raw = state_i.prg_bank[win];
    if (state_i.bank_order) begin
      prg_dec = {prg_raw[0], prg_raw[1], prg_raw[2], prg_raw[3], prg_raw[4], prg_raw[5]};
    end else begin
      prg_dec = prg_raw[7:2];
    end
    prg_bank = (win == 2'd3) ? state_i.prg_mask : (prg_dec & state_i.prg_mask);
    is_prg   = (addr_i >= PrgBase);

    // pattern fetch: control bit 1 swaps the 4K halves
    ppu_a = addr_i[12:0] ^ {state_i.ctrl[1], 12'd0};
    if (!ppu_a[12]) begin
      chr_bank = state_i.chr_bank[{2'd0, ppu_a[11]}] & ChrEvenMask & state_i.chr_mask;
    end else begin
      chr_bank = state_i.chr_bank[3'd2 + {1'b0, ppu_a[11:10]}] & state_i.chr_mask;
    end

    wr_o.en   = vld_i && (kind_i == KindCpuWrite) && !in_ram &&
                (addr_i >= RegBase) && (addr_i <= RegLast);
    wr_o.sel  = 4'(addr_i - RegBase);
    wr_o.data = data_i;

    target_o    = TgtNone;
    mapped_o    = '0;
    ram_write_o = 1'b0;
    if (is_cpu) begin
      if (in_ram) begin
        if (ram_ok) begin
          target_o    = TgtRam;
          mapped_o    = MapW'(ram_off[RamAw-1:0]);
          ram_write_o = (kind_i == KindCpuWrite);
        end
      end else if ((kind_i == KindCpuRead) && is_prg) begin
        target_o = TgtPrg;
        mapped_o = {prg_bank, addr_i[12:0]};
      end
    end else if (kind_i == KindPpuFetch) begin
      target_o = TgtChr;
      // 2K banks count in 1K units; bit 0 of the bank is always clear here
      if (!ppu_a[12]) mapped_o = MapW'({chr_bank[7:1], ppu_a[10:0]});
      else            mapped_o = MapW'({chr_bank, ppu_a[9:0]});
    end

    // mirroring reflects a control write made by this very beat
    ctrl_wr  = wr_o.en && (wr_o.sel == RegCtrl);
    mirror_o = ctrl_wr ? data_i[0] : state_i.ctrl[0];
  end

endmodule

// ===== design/bank_switch_mapper_x1_017_top.sv =====
// Top level of the bank switch mapper: input register, translation, result register.
// Depends on bsm_pkg, bsm_regs and bsm_xlate.
//
// channel  dir  signals                        payload
// s_axis   in   tvalid tready tdata tuser      tdata: addr, data; tuser: kind
// m_axis   out  tvalid tready tdata tuser      tdata: mapped_addr, ram_write,
//                                              mirror_vertical; tuser: target
// cfg      in   valid ready index data         index 0..2, data 8 bits
//
// One beat per cycle unless m_axis stalls; a taken beat goes to the input register,
// then its result to the result register. Each of the two holds one beat, so input
// stays ready while a result waits, until both are full and m_axis stalls.
// Bank register writes take effect for the very next beat. Reset clears the
// pipeline and loads the power-on bank values; cfg is always ready.
module bank_switch_mapper_x1_017_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] addr, [23:16] data
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [18:0] mapped_addr, [19] ram_write,
                                      // [20] mirror_vertical, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] target
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import bsm_pkg::*;

  logic        in_vld_q;
  logic [1:0]  in_kind_q;
  logic [15:0] in_addr_q;
  logic [7:0]  in_data_q;
  logic        out_vld_q;
  logic [1:0]  out_tgt_q;
  logic [MapW-1:0] out_map_q;
  logic        out_wr_q, out_mir_q;
  logic        advance, take;

  bsm_state_t state;
  bsm_wr_t    wr;
  target_e    tgt;
  logic [MapW-1:0] mapped;
  logic       ram_wr, mirror;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  bsm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_i        (wr),
    .state_o     (state)
  );

  bsm_xlate u_xlate (
    .vld_i       (advance),
    .kind_i      (in_kind_q),
    .addr_i      (in_addr_q),
    .data_i      (in_data_q),
    .state_i     (state),
    .wr_o        (wr),
    .target_o    (tgt),
    .mapped_o    (mapped),
    .ram_write_o (ram_wr),
    .mirror_o    (mirror)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take)         in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance)            out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_kind_q <= s_axis_tuser;
      in_addr_q <= s_axis_tdata[15:0];
      in_data_q <= s_axis_tdata[23:16];
    end
    // hold the result until it is taken
    if (advance) begin
      out_tgt_q <= tgt;
      out_map_q <= mapped;
      out_wr_q  <= ram_wr;
      out_mir_q <= mirror;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_tgt_q;
  assign m_axis_tdata  = {3'd0, out_mir_q, out_wr_q, out_map_q};

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  a_none_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == TgtNone)) |-> (m_axis_tdata[18:0] == '0))
    else $error("open bus result with non-zero address");

  a_wr_is_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[19]) |-> (m_axis_tuser == TgtRam))
    else $error("RAM write flagged outside work RAM");

  a_ctrl_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && (wr.sel == RegCtrl)) |=> (m_axis_tdata[20] == $past(in_data_q[0])))
    else $error("mirroring does not follow control write");

  a_chr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == TgtChr)) |-> !m_axis_tdata[18])
    else $error("character address out of range");
`endif

endmodule
